// ----- rtl/core/c_source_tokenizer_core_macros.svh -----
// Assertion macros used by the tokenizer's token queue.
`ifndef C_SOURCE_TOKENIZER_CORE_MACROS_SVH
`define C_SOURCE_TOKENIZER_CORE_MACROS_SVH
// Asserts that an antecedent implies a consequent in the same cycle.
`define CST_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Asserts that an antecedent implies a consequent in the next cycle.
`define CST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/cst_pkg.sv -----
// Package with token kinds, lexer modes and shared types of the tokenizer.
`timescale 1ns / 1ps
package cst_pkg;
  typedef enum logic [3:0] {
    M_IDLE, M_CR, M_BLANK, M_SLASH, M_LCOM, M_BCOM, M_PRE, M_STR, M_CHR,
    M_WORD, M_ZERO, M_HEX, M_DEC, M_SUF, M_OP1, M_OP2
  } mode_t;

  localparam logic [4:0] K_NEWLINE = 5'd0;
  localparam logic [4:0] K_BLANK   = 5'd1;
  localparam logic [4:0] K_COMMENT = 5'd2;
  localparam logic [4:0] K_PRE     = 5'd3;
  localparam logic [4:0] K_STRING  = 5'd4;
  localparam logic [4:0] K_CHAR    = 5'd5;
  localparam logic [4:0] K_LBRACE  = 5'd6;
  localparam logic [4:0] K_RBRACE  = 5'd7;
  localparam logic [4:0] K_LPAREN  = 5'd8;
  localparam logic [4:0] K_RPAREN  = 5'd9;
  localparam logic [4:0] K_LBRACK  = 5'd10;
  localparam logic [4:0] K_RBRACK  = 5'd11;
  localparam logic [4:0] K_SEMI    = 5'd12;
  localparam logic [4:0] K_WORD    = 5'd13;
  localparam logic [4:0] K_NUMBER  = 5'd14;
  localparam logic [4:0] K_OPER    = 5'd15;
  localparam logic [4:0] K_END     = 5'd16;

  localparam logic [4:0] TAB_RESET = 5'd8;
  localparam logic [7:0] UNDERSCORE = 8'h5f;
  localparam int MAX_TOKENS = 4;

  typedef struct packed {
    logic [2:0] count;
    logic       busy;
  } q_status_t;

  function automatic logic [4:0] mode_kind(input mode_t m);
    logic [4:0] k;
    begin
      case (m)
        M_IDLE, M_CR: k = K_NEWLINE;
        M_BLANK: k = K_BLANK;
        M_LCOM, M_BCOM: k = K_COMMENT;
        M_PRE: k = K_PRE;
        M_STR: k = K_STRING;
        M_CHR: k = K_CHAR;
        M_WORD: k = K_WORD;
        M_ZERO, M_HEX, M_DEC, M_SUF: k = K_NUMBER;
        default: k = K_OPER;
      endcase
      return k;
    end
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction
  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction
  function automatic logic is_wordc(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || b == UNDERSCORE;
  endfunction
  function automatic logic is_hex(input logic [7:0] b);
    return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction
  function automatic logic is_dec(input logic [7:0] b);
    return is_digit(b) || b == "." || b == "e" || b == "E" || b == "x" || b == "X" ||
           (b >= "a" && b <= "d") || b == "f" || (b >= "A" && b <= "D") || b == "F";
  endfunction
  function automatic logic is_suffix(input logic [7:0] b);
    return b == "u" || b == "U" || b == "l" || b == "L" || b == "f" || b == "F";
  endfunction
  function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
    logic r;
    begin
      if (b == "=")
        r = a == "=" || a == "!" || a == "<" || a == ">" || a == "+" || a == "-" ||
            a == "*" || a == "/" || a == "%" || a == "&" || a == "|" || a == "^";
      else if (a == b)
        r = a == "&" || a == "|" || a == "<" || a == ">" || a == "+" || a == "-";
      else
        r = a == "-" && b == ">";
      return r;
    end
  endfunction
endpackage

// ----- rtl/core/cst_stream_if.sv -----
// Valid/ready stream interface that carries one payload per transfer.
`timescale 1ns / 1ps
interface cst_stream_if #(
  parameter int W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/cst_front.sv -----
// Lexer front end: classifies each byte and produces up to four tokens per byte.
`timescale 1ns / 1ps
module cst_front #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [7:0]             byte_value,
  input  logic                   last_byte,
  input  logic [4:0]             tab_width,
  output logic [2:0]             tok_count,
  output logic [3:0][4:0]        tok_kind,
  output logic [3:0][LINE_BITS-1:0] tok_line,
  output logic [3:0][LINE_BITS-1:0] tok_col,
  output logic [3:0][OFFSET_BITS-1:0] tok_start,
  output logic [3:0][OFFSET_BITS-1:0] tok_len,
  output logic [3:0]             tok_last
);
  localparam logic [LINE_BITS-1:0] POS_MAX = {LINE_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0] ONE_L = {{(LINE_BITS-1){1'b0}}, 1'b1};
  localparam logic [LINE_BITS:0] INC1 = {{LINE_BITS{1'b0}}, 1'b1};
  localparam logic [LINE_BITS:0] INC2 = {{(LINE_BITS-1){1'b0}}, 2'd2};
  localparam logic [LINE_BITS:0] INC3 = {{(LINE_BITS-1){1'b0}}, 2'd3};

  cst_pkg::mode_t mode_r, mode_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt, col_r, col_nxt;
  logic [LINE_BITS-1:0] pline_r, pline_nxt, pcol_r, pcol_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt, pstart_r, pstart_nxt;
  logic [7:0] la0_r, la0_nxt, prev_r;
  logic esc_r, esc_nxt, star_r, star_nxt;

  function automatic logic [LINE_BITS-1:0] sat_add(input logic [LINE_BITS-1:0] a,
                                                   input logic [LINE_BITS:0] n);
    logic [LINE_BITS+1:0] s;
    begin
      s = {1'b0, a} + {1'b0, n};
      return (s > {2'b0, POS_MAX}) ? POS_MAX : s[LINE_BITS-1:0];
    end
  endfunction

  always_comb begin
    logic [OFFSET_BITS-1:0] pos, after, len;
    logic [LINE_BITS-1:0] col_old;
    logic again, done;
    cst_pkg::mode_t m;
    pos = off_r;
    after = off_r + 1'b1;
    mode_nxt = mode_r;
    line_nxt = line_r; col_nxt = col_r; pline_nxt = pline_r; pcol_nxt = pcol_r;
    pstart_nxt = pstart_r; la0_nxt = la0_r; esc_nxt = esc_r; star_nxt = star_r;
    off_nxt = off_r;
    tok_count = '0;
    tok_kind = '0; tok_line = '0; tok_col = '0; tok_start = '0; tok_len = '0;
    tok_last = '0;
    again = 1'b1;
    done = 1'b0;
    len = '0; col_old = '0; m = cst_pkg::M_IDLE;
    // A byte passes through at most four modes before it is consumed.
    for (int it = 0; it < 4; it++) begin
      if (again && !done) begin
        again = 1'b0;
        case (mode_nxt)
          cst_pkg::M_IDLE: begin
            done = 1'b1;
            pstart_nxt = pos; pline_nxt = line_nxt; pcol_nxt = col_nxt;
            case (byte_value)
              "\n": begin
                tok_kind[tok_count[1:0]] = cst_pkg::K_NEWLINE;
                tok_line[tok_count[1:0]] = line_nxt; tok_col[tok_count[1:0]] = col_nxt;
                tok_start[tok_count[1:0]] = pos;
                tok_len[tok_count[1:0]] = {{(OFFSET_BITS-1){1'b0}}, 1'b1};
                tok_count = tok_count + 1'b1;
                if (line_nxt != POS_MAX) line_nxt = line_nxt + 1'b1;
                col_nxt = '0;
              end
              8'h0d: mode_nxt = cst_pkg::M_CR;
              " ": begin mode_nxt = cst_pkg::M_BLANK; col_nxt = sat_add(col_nxt, INC1); end
              "\t": begin
                mode_nxt = cst_pkg::M_BLANK;
                col_nxt = sat_add(col_nxt, {{(LINE_BITS-4){1'b0}}, tab_width});
              end
              "/": mode_nxt = cst_pkg::M_SLASH;
              "#": mode_nxt = cst_pkg::M_PRE;
              "\"": begin
                mode_nxt = cst_pkg::M_STR; esc_nxt = 1'b0; star_nxt = 1'b0;
                col_nxt = sat_add(col_nxt, INC1);
              end
              "'": begin
                mode_nxt = cst_pkg::M_CHR; esc_nxt = 1'b0; star_nxt = 1'b0;
                col_nxt = sat_add(col_nxt, INC1);
              end
              "{", "}", "(", ")", "[", "]", ";": begin
                case (byte_value)
                  "{": tok_kind[tok_count[1:0]] = cst_pkg::K_LBRACE;
                  "}": tok_kind[tok_count[1:0]] = cst_pkg::K_RBRACE;
                  "(": tok_kind[tok_count[1:0]] = cst_pkg::K_LPAREN;
                  ")": tok_kind[tok_count[1:0]] = cst_pkg::K_RPAREN;
                  "[": tok_kind[tok_count[1:0]] = cst_pkg::K_LBRACK;
                  "]": tok_kind[tok_count[1:0]] = cst_pkg::K_RBRACK;
                  default: tok_kind[tok_count[1:0]] = cst_pkg::K_SEMI;
                endcase
                tok_line[tok_count[1:0]] = line_nxt; tok_col[tok_count[1:0]] = col_nxt;
                tok_start[tok_count[1:0]] = pos;
                tok_len[tok_count[1:0]] = {{(OFFSET_BITS-1){1'b0}}, 1'b1};
                tok_count = tok_count + 1'b1;
                col_nxt = sat_add(col_nxt, INC1);
              end
              default: begin
                if (cst_pkg::is_alpha(byte_value) || byte_value == cst_pkg::UNDERSCORE) begin
                  mode_nxt = cst_pkg::M_WORD; col_nxt = sat_add(col_nxt, INC1);
                end else if (cst_pkg::is_digit(byte_value)) begin
                  mode_nxt = (byte_value == "0") ? cst_pkg::M_ZERO : cst_pkg::M_DEC;
                  col_nxt = sat_add(col_nxt, INC1);
                end else begin
                  mode_nxt = cst_pkg::M_OP1; la0_nxt = byte_value;
                end
              end
            endcase
          end
          cst_pkg::M_CR: begin
            tok_kind[tok_count[1:0]] = cst_pkg::K_NEWLINE;
            tok_line[tok_count[1:0]] = pline_nxt; tok_col[tok_count[1:0]] = pcol_nxt;
            tok_start[tok_count[1:0]] = pstart_nxt;
            tok_len[tok_count[1:0]] = ((byte_value == "\n") ? after : pos) - pstart_nxt;
            tok_count = tok_count + 1'b1;
            mode_nxt = cst_pkg::M_IDLE;
            if (line_nxt != POS_MAX) line_nxt = line_nxt + 1'b1;
            col_nxt = '0;
            if (byte_value == "\n") done = 1'b1; else again = 1'b1;
          end
          cst_pkg::M_BLANK: begin
            if (byte_value == " ") begin col_nxt = sat_add(col_nxt, INC1); done = 1'b1; end
            else if (byte_value == "\t") begin
              col_nxt = sat_add(col_nxt, {{(LINE_BITS-4){1'b0}}, tab_width}); done = 1'b1;
            end else begin
              tok_kind[tok_count[1:0]] = cst_pkg::K_BLANK;
              tok_line[tok_count[1:0]] = pline_nxt; tok_col[tok_count[1:0]] = pcol_nxt;
              tok_start[tok_count[1:0]] = pstart_nxt; tok_len[tok_count[1:0]] = pos - pstart_nxt;
              tok_count = tok_count + 1'b1;
              mode_nxt = cst_pkg::M_IDLE; again = 1'b1;
            end
          end
          cst_pkg::M_SLASH: begin
            if (byte_value == "/") begin
              mode_nxt = cst_pkg::M_LCOM; col_nxt = sat_add(col_nxt, INC2); done = 1'b1;
            end else if (byte_value == "*") begin
              mode_nxt = cst_pkg::M_BCOM; esc_nxt = 1'b0; star_nxt = 1'b0; done = 1'b1;
            end else begin
              mode_nxt = cst_pkg::M_OP1; la0_nxt = "/"; again = 1'b1;
            end
          end
          cst_pkg::M_LCOM: begin
            if (byte_value == "\n") begin
              tok_kind[tok_count[1:0]] = cst_pkg::K_COMMENT;
              tok_line[tok_count[1:0]] = pline_nxt; tok_col[tok_count[1:0]] = pcol_nxt;
              tok_start[tok_count[1:0]] = pstart_nxt; tok_len[tok_count[1:0]] = pos - pstart_nxt;
              tok_count = tok_count + 1'b1;
              mode_nxt = cst_pkg::M_IDLE; again = 1'b1;
            end else begin
              col_nxt = sat_add(col_nxt, INC1); done = 1'b1;
            end
          end
          cst_pkg::M_BCOM: begin
            done = 1'b1;
            if (star_nxt && byte_value == "/") begin
              star_nxt = 1'b0; esc_nxt = 1'b0;
              col_nxt = sat_add(col_nxt, INC2);
              tok_kind[tok_count[1:0]] = cst_pkg::K_COMMENT;
              tok_line[tok_count[1:0]] = pline_nxt; tok_col[tok_count[1:0]] = pcol_nxt;
              tok_start[tok_count[1:0]] = pstart_nxt;
              tok_len[tok_count[1:0]] = after - pstart_nxt;
              tok_count = tok_count + 1'b1;
              mode_nxt = cst_pkg::M_IDLE;
            end else begin
              if (star_nxt) begin
                star_nxt = 1'b0; esc_nxt = 1'b0; col_nxt = sat_add(col_nxt, INC1);
              end
              if (last_byte) begin
                tok_kind[tok_count[1:0]] = cst_pkg::K_COMMENT;
                tok_line[tok_count[1:0]] = pline_nxt; tok_col[tok_count[1:0]] = pcol_nxt;
                tok_start[tok_count[1:0]] = pstart_nxt;
                tok_len[tok_count[1:0]] = pos - pstart_nxt;
                tok_count = tok_count + 1'b1;
                mode_nxt = cst_pkg::M_IDLE;
                col_nxt = sat_add(col_nxt, INC2);
                done = 1'b0; again = 1'b1;
              end else if (byte_value == "*") star_nxt = 1'b1;
              else if (byte_value == "\n") begin
                if (line_nxt != POS_MAX) line_nxt = line_nxt + 1'b1;
                col_nxt = '0;
              end else col_nxt = sat_add(col_nxt, INC1);
            end
          end
          cst_pkg::M_PRE: begin
            if (byte_value == "\n" && prev_r != "\\") begin
              tok_kind[tok_count[1:0]] = cst_pkg::K_PRE;
              tok_line[tok_count[1:0]] = pline_nxt; tok_col[tok_count[1:0]] = pcol_nxt;
              tok_start[tok_count[1:0]] = pstart_nxt; tok_len[tok_count[1:0]] = pos - pstart_nxt;
              tok_count = tok_count + 1'b1;
              mode_nxt = cst_pkg::M_IDLE; col_nxt = '0; again = 1'b1;
            end else begin
              if (byte_value == "\n") begin
                if (line_nxt != POS_MAX) line_nxt = line_nxt + 1'b1;
                col_nxt = '0;
              end
              done = 1'b1;
            end
          end
          cst_pkg::M_STR, cst_pkg::M_CHR: begin
            done = 1'b1;
            if (esc_nxt) begin esc_nxt = 1'b0; col_nxt = sat_add(col_nxt, INC1); end
            else if (byte_value == "\\") begin esc_nxt = 1'b1; col_nxt = sat_add(col_nxt, INC1); end
            else if ((mode_nxt == cst_pkg::M_STR && byte_value == "\"") ||
                     (mode_nxt == cst_pkg::M_CHR && byte_value == "'")) begin
              col_nxt = sat_add(col_nxt, INC1);
              tok_kind[tok_count[1:0]] = (mode_nxt == cst_pkg::M_STR) ? cst_pkg::K_STRING :
                                                                         cst_pkg::K_CHAR;
              tok_line[tok_count[1:0]] = pline_nxt; tok_col[tok_count[1:0]] = pcol_nxt;
              tok_start[tok_count[1:0]] = pstart_nxt;
              tok_len[tok_count[1:0]] = after - pstart_nxt;
              tok_count = tok_count + 1'b1;
              mode_nxt = cst_pkg::M_IDLE;
            end else if (mode_nxt == cst_pkg::M_STR && byte_value == "\n") begin
              if (line_nxt != POS_MAX) line_nxt = line_nxt + 1'b1;
              col_nxt = '0;
            end else col_nxt = sat_add(col_nxt, INC1);
          end
          cst_pkg::M_WORD, cst_pkg::M_SUF: begin
            if ((mode_nxt == cst_pkg::M_WORD) ? cst_pkg::is_wordc(byte_value) :
                cst_pkg::is_suffix(byte_value)) begin
              col_nxt = sat_add(col_nxt, INC1); done = 1'b1;
            end else begin
              tok_kind[tok_count[1:0]] = (mode_nxt == cst_pkg::M_WORD) ? cst_pkg::K_WORD :
                                                                          cst_pkg::K_NUMBER;
              tok_line[tok_count[1:0]] = pline_nxt; tok_col[tok_count[1:0]] = pcol_nxt;
              tok_start[tok_count[1:0]] = pstart_nxt; tok_len[tok_count[1:0]] = pos - pstart_nxt;
              tok_count = tok_count + 1'b1;
              mode_nxt = cst_pkg::M_IDLE; again = 1'b1;
            end
          end
          cst_pkg::M_ZERO: begin
            if (byte_value == "x" || byte_value == "X") begin
              mode_nxt = cst_pkg::M_HEX; col_nxt = sat_add(col_nxt, INC1); done = 1'b1;
            end else begin mode_nxt = cst_pkg::M_DEC; again = 1'b1; end
          end
          cst_pkg::M_HEX, cst_pkg::M_DEC: begin
            if ((mode_nxt == cst_pkg::M_HEX) ? cst_pkg::is_hex(byte_value) :
                cst_pkg::is_dec(byte_value)) begin
              col_nxt = sat_add(col_nxt, INC1); done = 1'b1;
            end else begin mode_nxt = cst_pkg::M_SUF; again = 1'b1; end
          end
          cst_pkg::M_OP1: begin
            if ((la0_nxt == "<" || la0_nxt == ">") && byte_value == la0_nxt) begin
              mode_nxt = cst_pkg::M_OP2; done = 1'b1;
            end else begin
              tok_kind[tok_count[1:0]] = cst_pkg::K_OPER;
              tok_line[tok_count[1:0]] = pline_nxt; tok_col[tok_count[1:0]] = pcol_nxt;
              tok_start[tok_count[1:0]] = pstart_nxt;
              mode_nxt = cst_pkg::M_IDLE;
              if (cst_pkg::is_pair(la0_nxt, byte_value)) begin
                tok_len[tok_count[1:0]] = after - pstart_nxt;
                col_nxt = sat_add(col_nxt, INC2); done = 1'b1;
              end else begin
                tok_len[tok_count[1:0]] = pos - pstart_nxt;
                col_nxt = sat_add(col_nxt, INC1); again = 1'b1;
              end
              tok_count = tok_count + 1'b1;
            end
          end
          default: begin
            tok_kind[tok_count[1:0]] = cst_pkg::K_OPER;
            tok_line[tok_count[1:0]] = pline_nxt; tok_col[tok_count[1:0]] = pcol_nxt;
            tok_start[tok_count[1:0]] = pstart_nxt;
            mode_nxt = cst_pkg::M_IDLE;
            if (byte_value == "=") begin
              tok_len[tok_count[1:0]] = after - pstart_nxt;
              col_nxt = sat_add(col_nxt, INC3); done = 1'b1;
            end else begin
              tok_len[tok_count[1:0]] = pos - pstart_nxt;
              col_nxt = sat_add(col_nxt, INC2); again = 1'b1;
            end
            tok_count = tok_count + 1'b1;
          end
        endcase
      end
    end
    if (last_byte) begin
      if (mode_nxt != cst_pkg::M_IDLE) begin
        m = mode_nxt;
        len = after - pstart_nxt;
        tok_kind[tok_count[1:0]] = cst_pkg::mode_kind(m);
        tok_line[tok_count[1:0]] = pline_nxt; tok_col[tok_count[1:0]] = pcol_nxt;
        tok_start[tok_count[1:0]] = pstart_nxt; tok_len[tok_count[1:0]] = len;
        tok_count = tok_count + 1'b1;
        col_old = col_nxt;
        if (m == cst_pkg::M_CR) begin
          if (line_nxt != POS_MAX) line_nxt = line_nxt + 1'b1;
          col_nxt = '0;
        end else if (m == cst_pkg::M_PRE) col_nxt = '0;
        else if (m == cst_pkg::M_BCOM) col_nxt = sat_add(col_old, INC2);
        else if (m == cst_pkg::M_SLASH || m == cst_pkg::M_OP1 || m == cst_pkg::M_OP2)
          col_nxt = sat_add(col_old, {{(LINE_BITS-1){1'b0}}, len[1:0] + 2'd0});
      end
      if (tok_count < 3'd4) begin
        tok_kind[tok_count[1:0]] = cst_pkg::K_END;
        tok_line[tok_count[1:0]] = line_nxt; tok_col[tok_count[1:0]] = col_nxt;
        tok_start[tok_count[1:0]] = after; tok_len[tok_count[1:0]] = '0;
        tok_last[tok_count[1:0]] = 1'b1;
        tok_count = tok_count + 1'b1;
      end
      mode_nxt = cst_pkg::M_IDLE;
      line_nxt = ONE_L; col_nxt = '0; off_nxt = '0; pstart_nxt = '0;
      pline_nxt = ONE_L; pcol_nxt = '0; la0_nxt = '0; esc_nxt = 1'b0; star_nxt = 1'b0;
    end else begin
      off_nxt = after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= cst_pkg::M_IDLE;
      line_r <= ONE_L; col_r <= '0; off_r <= '0; pstart_r <= '0;
      pline_r <= ONE_L; pcol_r <= '0; la0_r <= '0; prev_r <= '0;
      esc_r <= 1'b0; star_r <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt;
      line_r <= line_nxt; col_r <= col_nxt; off_r <= off_nxt; pstart_r <= pstart_nxt;
      pline_r <= pline_nxt; pcol_r <= pcol_nxt; la0_r <= la0_nxt;
      prev_r <= last_byte ? 8'd0 : byte_value;
      esc_r <= esc_nxt; star_r <= star_nxt;
    end
  end
endmodule

// ----- rtl/core/cst_token_queue.sv -----
// Token queue that holds token groups and hands them out one token per transfer.
`timescale 1ns / 1ps
`include "c_source_tokenizer_core_macros.svh"
module cst_token_queue #(
  parameter int W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [2:0]        push_count,
  input  logic [3:0][W-1:0] push_data,
  output logic              can_push,
  output logic              out_valid,
  output logic [W-1:0]      out_data,
  input  logic              out_ready,
  output cst_pkg::q_status_t status
);
  localparam int DEPTH = 8;
  logic [W-1:0] mem_r [DEPTH];
  logic [2:0] wp_r, rp_r;
  logic [3:0] cnt_r, cnt_nxt;
  logic pop;

  assign pop = out_valid && out_ready;
  assign out_valid = cnt_r != 4'd0;
  assign out_data = mem_r[rp_r];
  assign can_push = cnt_r <= 4'd4;
  assign cnt_nxt = cnt_r + ((push) ? {1'b0, push_count} : 4'd0) - {3'd0, pop};
  assign status.count = cnt_r[2:0];
  assign status.busy = out_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < push_count) mem_r[wp_r + 3'(i)] <= push_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + push_count;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  `CST_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, cnt_r <= 4'd4)
  `CST_ASSERT_NEXT(a_count_track, clk, rst_n, 1'b1, cnt_r == $past(cnt_nxt))
  `CST_ASSERT_IMPLY(a_valid_count, clk, rst_n, out_valid, cnt_r <= 4'd8)
endmodule

// ----- rtl/core/c_source_tokenizer_core.sv -----
// Top level of the C source tokenizer with its configuration register.
//   channel  direction  payload
//   in_      sink       byte_value, last_byte
//   out_     source     token_kind, line, column, start, length, last_token
//   cfg_     APB        tab_width at address 0
// One byte is taken per cycle and yields up to four tokens in that cycle.
// Tokens leave one per transfer from an eight-entry queue, so input stalls
// while the queue holds more than four tokens. Reset is synchronous and
// clears all lexer state and sets tab_width to 8.
`timescale 1ns / 1ps
module c_source_tokenizer_core #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  cst_stream_if.sink   in_ch,
  cst_stream_if.source out_ch,
  input  logic       cfg_psel,
  input  logic       cfg_penable,
  input  logic       cfg_pwrite,
  input  logic [0:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic       cfg_pready
);
  localparam int TW = 5 + 2 * LINE_BITS + 2 * OFFSET_BITS + 1;
  logic [4:0] tab_r;
  logic step;
  logic [2:0] cnt;
  logic [3:0][4:0] k;
  logic [3:0][LINE_BITS-1:0] ln, cl;
  logic [3:0][OFFSET_BITS-1:0] st, lg;
  logic [3:0] lt;
  logic [3:0][TW-1:0] pd;
  logic [TW-1:0] od;
  logic can_push;
  cst_pkg::q_status_t qs;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 1'b0) ? {27'd0, tab_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) tab_r <= cst_pkg::TAB_RESET;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 1'b0)
      tab_r <= cfg_pwdata[4:0];
  end

  assign in_ch.ready = can_push;
  assign step = in_ch.valid && in_ch.ready;

  cst_front #(.OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS)) u_front (
    .clk, .rst_n, .step, .byte_value(in_ch.data[8:1]), .last_byte(in_ch.data[0]),
    .tab_width(tab_r), .tok_count(cnt), .tok_kind(k), .tok_line(ln), .tok_col(cl),
    .tok_start(st), .tok_len(lg), .tok_last(lt)
  );

  always_comb begin
    for (int i = 0; i < 4; i++) pd[i] = {k[i], ln[i], cl[i], st[i], lg[i], lt[i]};
  end

  cst_token_queue #(.W(TW)) u_queue (
    .clk, .rst_n, .push(step), .push_count(cnt), .push_data(pd), .can_push,
    .out_valid(out_ch.valid), .out_data(od), .out_ready(out_ch.ready), .status(qs)
  );

  assign out_ch.data = od;
endmodule

// ----- verif/tb_c_source_tokenizer_core.sv -----
// Self-checking testbench for the C source tokenizer core: directed table plus random C text.
`timescale 1ns / 1ps
module tb_c_source_tokenizer_core;
  localparam int OFF_W = 24;
  localparam int POS_W = 16;
  localparam longint OFF_MASK = (64'd1 << OFF_W) - 1;
  localparam longint POS_MAX = (64'd1 << POS_W) - 1;
  localparam int TOK_W = 5 + 16 + 16 + 24 + 24 + 1;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [23:0] start;
    logic [23:0] length;
    logic        last;
  } token_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
    logic       typed;
    token_t     tok;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [0:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  cst_stream_if #(.W(9)) in_ch ();
  cst_stream_if #(.W(TOK_W)) out_ch ();

  c_source_tokenizer_core uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  token_t expected_tokens[$];
  logic [7:0] text_bytes[$];
  int errors = 0;
  int bytes_sent = 0;
  int tokens_seen = 0;
  int idle_cycles = 0;
  bit idling_on = 1'b1;
  bit hold_request = 1'b0;
  bit done = 1'b0;

  // Predictor state.
  logic [4:0] tab_width;
  cst_pkg::mode_t lx_mode;
  longint cur_line, cur_col, offset, pend_start, pend_line, pend_col;
  logic [7:0] look0;
  logic [7:0] prev_byte;
  bit esc_flag, star_flag;
  int emitted;

  function automatic bit is_al(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction
  function automatic bit is_dg(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction
  function automatic bit is_hx(logic [7:0] b);
    return is_dg(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction
  function automatic bit is_dc(logic [7:0] b);
    return is_dg(b) || b == "." || b == "e" || b == "E" || b == "x" || b == "X" ||
           (b >= "a" && b <= "d") || b == "f" || (b >= "A" && b <= "D") || b == "F";
  endfunction
  function automatic bit is_sf(logic [7:0] b);
    return b == "u" || b == "U" || b == "l" || b == "L" || b == "f" || b == "F";
  endfunction
  function automatic bit op_pair(logic [7:0] a, logic [7:0] b);
    if (b == "=")
      return a == "=" || a == "!" || a == "<" || a == ">" || a == "+" || a == "-" ||
             a == "*" || a == "/" || a == "%" || a == "&" || a == "|" || a == "^";
    if (a == b)
      return a == "&" || a == "|" || a == "<" || a == ">" || a == "+" || a == "-";
    return a == "-" && b == ">";
  endfunction
  function automatic logic [4:0] kind_of_mode(cst_pkg::mode_t m);
    case (m)
      cst_pkg::M_IDLE, cst_pkg::M_CR: return cst_pkg::K_NEWLINE;
      cst_pkg::M_BLANK: return cst_pkg::K_BLANK;
      cst_pkg::M_LCOM, cst_pkg::M_BCOM: return cst_pkg::K_COMMENT;
      cst_pkg::M_PRE: return cst_pkg::K_PRE;
      cst_pkg::M_STR: return cst_pkg::K_STRING;
      cst_pkg::M_CHR: return cst_pkg::K_CHAR;
      cst_pkg::M_WORD: return cst_pkg::K_WORD;
      cst_pkg::M_ZERO, cst_pkg::M_HEX, cst_pkg::M_DEC, cst_pkg::M_SUF:
        return cst_pkg::K_NUMBER;
      default: return cst_pkg::K_OPER;
    endcase
  endfunction

  function automatic void push_token(logic [4:0] k, longint ln, longint cl, longint st,
                                     longint len, bit lst);
    token_t t;
    if (emitted >= cst_pkg::MAX_TOKENS) return;
    t.kind = k; t.line = ln[15:0]; t.column = cl[15:0];
    t.start = st[23:0]; t.length = len[23:0]; t.last = lst;
    expected_tokens.push_back(t);
    emitted++;
  endfunction

  function automatic void col_add(longint n);
    cur_col += n;
    if (cur_col > POS_MAX) cur_col = POS_MAX;
  endfunction
  function automatic void next_line();
    if (cur_line < POS_MAX) cur_line++;
    cur_col = 0;
  endfunction
  function automatic void clear_text();
    lx_mode = cst_pkg::M_IDLE; cur_line = 1; cur_col = 0; offset = 0;
    pend_start = 0; pend_line = 1; pend_col = 0;
    look0 = 0; prev_byte = 0; esc_flag = 0; star_flag = 0;
  endfunction
  function automatic void open_token(cst_pkg::mode_t m);
    pend_start = offset; pend_line = cur_line; pend_col = cur_col; lx_mode = m;
  endfunction
  function automatic void close_token(logic [4:0] k, longint upto);
    push_token(k, pend_line, pend_col, pend_start, (upto - pend_start) & OFF_MASK, 0);
    lx_mode = cst_pkg::M_IDLE;
  endfunction

  function automatic void start_token(logic [7:0] b);
    case (b)
      8'h0a: begin
        push_token(cst_pkg::K_NEWLINE, cur_line, cur_col, offset, 1, 0); next_line();
      end
      8'h0d: open_token(cst_pkg::M_CR);
      " ": begin open_token(cst_pkg::M_BLANK); col_add(1); end
      8'h09: begin open_token(cst_pkg::M_BLANK); col_add(tab_width); end
      "/": open_token(cst_pkg::M_SLASH);
      "#": open_token(cst_pkg::M_PRE);
      8'h22: begin open_token(cst_pkg::M_STR); esc_flag = 0; star_flag = 0; col_add(1); end
      8'h27: begin open_token(cst_pkg::M_CHR); esc_flag = 0; star_flag = 0; col_add(1); end
      "{", "}", "(", ")", "[", "]", ";": begin
        push_token(b == "{" ? cst_pkg::K_LBRACE : b == "}" ? cst_pkg::K_RBRACE :
                   b == "(" ? cst_pkg::K_LPAREN : b == ")" ? cst_pkg::K_RPAREN :
                   b == "[" ? cst_pkg::K_LBRACK : b == "]" ? cst_pkg::K_RBRACK :
                   cst_pkg::K_SEMI, cur_line, cur_col, offset, 1, 0);
        col_add(1);
      end
      default: begin
        if (is_al(b) || b == cst_pkg::UNDERSCORE) begin
          open_token(cst_pkg::M_WORD); col_add(1);
        end else if (is_dg(b)) begin
          open_token(b == "0" ? cst_pkg::M_ZERO : cst_pkg::M_DEC); col_add(1);
        end else begin
          open_token(cst_pkg::M_OP1); look0 = b;
        end
      end
    endcase
  endfunction

  function automatic void predict_byte(logic [7:0] b, bit lst);
    longint pos, after, len;
    bit again;
    cst_pkg::mode_t m;
    emitted = 0;
    pos = offset;
    after = (pos + 1) & OFF_MASK;
    again = 1;
    while (again) begin
      again = 0;
      case (lx_mode)
        cst_pkg::M_IDLE: start_token(b);
        cst_pkg::M_CR: begin
          if (b == 8'h0a) begin close_token(cst_pkg::K_NEWLINE, after); next_line(); end
          else begin close_token(cst_pkg::K_NEWLINE, pos); next_line(); again = 1; end
        end
        cst_pkg::M_BLANK: begin
          if (b == " ") col_add(1);
          else if (b == 8'h09) col_add(tab_width);
          else begin close_token(cst_pkg::K_BLANK, pos); again = 1; end
        end
        cst_pkg::M_SLASH: begin
          if (b == "/") begin lx_mode = cst_pkg::M_LCOM; col_add(2); end
          else if (b == "*") begin
            lx_mode = cst_pkg::M_BCOM; esc_flag = 0; star_flag = 0;
          end else begin lx_mode = cst_pkg::M_OP1; look0 = "/"; again = 1; end
        end
        cst_pkg::M_LCOM: begin
          if (b == 8'h0a) begin close_token(cst_pkg::K_COMMENT, pos); again = 1; end
          else col_add(1);
        end
        cst_pkg::M_BCOM: begin
          bit closed;
          closed = 0;
          if (star_flag) begin
            esc_flag = 0; star_flag = 0;
            if (b == "/") begin
              col_add(2); close_token(cst_pkg::K_COMMENT, after); closed = 1;
            end else col_add(1);
          end
          if (!closed) begin
            if (lst) begin
              close_token(cst_pkg::K_COMMENT, pos); col_add(2); again = 1;
            end else if (b == "*") star_flag = 1;
            else if (b == 8'h0a) next_line();
            else col_add(1);
          end
        end
        cst_pkg::M_PRE: begin
          if (b == 8'h0a) begin
            if (prev_byte == "\\") next_line();
            else begin close_token(cst_pkg::K_PRE, pos); cur_col = 0; again = 1; end
          end
        end
        cst_pkg::M_STR, cst_pkg::M_CHR: begin
          if (esc_flag) begin esc_flag = 0; col_add(1); end
          else if (b == "\\") begin esc_flag = 1; col_add(1); end
          else if ((lx_mode == cst_pkg::M_STR && b == 8'h22) ||
                   (lx_mode == cst_pkg::M_CHR && b == 8'h27)) begin
            col_add(1);
            close_token(lx_mode == cst_pkg::M_STR ? cst_pkg::K_STRING : cst_pkg::K_CHAR,
                        after);
          end else if (lx_mode == cst_pkg::M_STR && b == 8'h0a) next_line();
          else col_add(1);
        end
        cst_pkg::M_WORD: begin
          if (is_al(b) || is_dg(b) || b == cst_pkg::UNDERSCORE) col_add(1);
          else begin close_token(cst_pkg::K_WORD, pos); again = 1; end
        end
        cst_pkg::M_ZERO: begin
          if (b == "x" || b == "X") begin lx_mode = cst_pkg::M_HEX; col_add(1); end
          else begin lx_mode = cst_pkg::M_DEC; again = 1; end
        end
        cst_pkg::M_HEX: begin
          if (is_hx(b)) col_add(1); else begin lx_mode = cst_pkg::M_SUF; again = 1; end
        end
        cst_pkg::M_DEC: begin
          if (is_dc(b)) col_add(1); else begin lx_mode = cst_pkg::M_SUF; again = 1; end
        end
        cst_pkg::M_SUF: begin
          if (is_sf(b)) col_add(1);
          else begin close_token(cst_pkg::K_NUMBER, pos); again = 1; end
        end
        cst_pkg::M_OP1: begin
          if ((look0 == "<" || look0 == ">") && b == look0) lx_mode = cst_pkg::M_OP2;
          else if (op_pair(look0, b)) begin
            close_token(cst_pkg::K_OPER, after); col_add(2);
          end else begin close_token(cst_pkg::K_OPER, pos); col_add(1); again = 1; end
        end
        cst_pkg::M_OP2: begin
          if (b == "=") begin close_token(cst_pkg::K_OPER, after); col_add(3); end
          else begin close_token(cst_pkg::K_OPER, pos); col_add(2); again = 1; end
        end
        default: begin lx_mode = cst_pkg::M_IDLE; again = 1; end
      endcase
    end
    prev_byte = b;
    after = (offset + 1) & OFF_MASK;
    if (lst) begin
      if (lx_mode != cst_pkg::M_IDLE) begin
        m = lx_mode;
        len = (after - pend_start) & OFF_MASK;
        close_token(kind_of_mode(m), after);
        if (m == cst_pkg::M_CR) next_line();
        else if (m == cst_pkg::M_PRE) cur_col = 0;
        else if (m == cst_pkg::M_BCOM) col_add(2);
        else if (m == cst_pkg::M_SLASH || m == cst_pkg::M_OP1 || m == cst_pkg::M_OP2)
          col_add(len);
      end
      push_token(cst_pkg::K_END, cur_line, cur_col, after, 0, 1);
      clear_text();
    end else begin
      offset = after;
    end
  endfunction

  // Directed table: all single-byte tokens, comments, literals, numbers, operators.
  stim_row_t directed[$];
  function automatic void add_row(logic [7:0] v, bit lst, bit typed = 0,
                                  token_t t = '0);
    stim_row_t r;
    r.value = v; r.last = lst; r.typed = typed; r.tok = t;
    directed.push_back(r);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_row(s[i], 0);
  endfunction

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  // Appends one lexically plausible fragment of C to the text buffer.
  function automatic void add_fragment();
    int n;
    n = $urandom_range(3, 0);
    case ($urandom_range(12))
      0: begin
        text_bytes.push_back(pick("abcxyzQRS_"));
        repeat (n + $urandom_range(3)) text_bytes.push_back(pick("az09_KZ"));
      end
      1: begin
        if ($urandom_range(1)) begin
          text_bytes.push_back("0"); text_bytes.push_back(pick("xX"));
          repeat (n + 1) text_bytes.push_back(pick("0123456789abcdefABCDEF"));
        end else begin
          repeat (n + 1) text_bytes.push_back(pick("0123456789.eE"));
        end
        repeat ($urandom_range(2)) text_bytes.push_back(pick("uUlLfF"));
      end
      2: begin
        text_bytes.push_back(8'h22);
        repeat (n + 1) text_bytes.push_back(pick("ab \\\"'\n"));
        text_bytes.push_back(8'h22);
      end
      3: begin
        text_bytes.push_back(8'h27);
        if ($urandom_range(1)) text_bytes.push_back("\\");
        text_bytes.push_back(pick("an'\n\\"));
        text_bytes.push_back(8'h27);
      end
      4: begin
        text_bytes.push_back("/"); text_bytes.push_back("/");
        repeat (n) text_bytes.push_back(pick("x */\t"));
        text_bytes.push_back(8'h0a);
      end
      5: begin
        text_bytes.push_back("/"); text_bytes.push_back("*");
        repeat (n) text_bytes.push_back(pick("a*/\n "));
        text_bytes.push_back("*"); text_bytes.push_back("/");
      end
      6: begin
        text_bytes.push_back("#");
        repeat (n) text_bytes.push_back(pick("d e\\"));
        if ($urandom_range(1)) begin text_bytes.push_back("\\"); text_bytes.push_back(8'h0a); end
        text_bytes.push_back("x"); text_bytes.push_back(8'h0a);
      end
      7: repeat ($urandom_range(3, 1)) text_bytes.push_back(pick("+-*/%&|^<>=!~?:.,"));
      8: repeat (n + 1) text_bytes.push_back(pick(" \t"));
      9: begin
        text_bytes.push_back(pick("\n\r"));
        if ($urandom_range(1)) text_bytes.push_back(8'h0a);
      end
      10: text_bytes.push_back(pick("{}()[];"));
      default: text_bytes.push_back(8'($urandom_range(255)));
    endcase
  endfunction

  task automatic send_byte(logic [7:0] v, bit lst);
    if (idling_on && $urandom_range(3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data = {v, lst};
    do @(posedge clk); while (!in_ch.ready);
    predict_byte(v, lst);
    bytes_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_tokens.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_tab(logic [31:0] v);
    wait_drained();
    cfg_psel = 1'b1; cfg_pwrite = 1'b1; cfg_paddr = '0; cfg_pwdata = v;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    tab_width = v[4:0];
    @(negedge clk);
    cfg_psel = 1'b1;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    if (cfg_prdata[4:0] != v[4:0]) begin
      errors++;
      if (errors <= 10) $display("tab_width readback: expected %0d, got %0d", v[4:0], cfg_prdata);
    end
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0;
  endtask

  task automatic random_texts(int budget);
    int target;
    int sent;
    sent = 0;
    while (sent < budget) begin
      text_bytes.delete();
      target = ($urandom_range(7) == 0) ? 1 : $urandom_range(30, 3);
      while (text_bytes.size() < target) add_fragment();
      if ($urandom_range(5) == 0 && text_bytes.size() > 1)
        text_bytes = text_bytes[0:$urandom_range(text_bytes.size() - 1)];
      foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
      sent += text_bytes.size();
    end
  endtask

  // Result side: random stalls, one long hold-off on request.
  initial begin
    token_t got, want;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      if (idling_on && $urandom_range(4) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(3, 1)) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        tokens_seen++;
        if (expected_tokens.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected token %p", got);
        end else begin
          want = expected_tokens.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("token mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n || done)
        idle_cycles = 0;
      else if (++idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    tab_width = cst_pkg::TAB_RESET;
    clear_text();
    add_row(8'h0a, 0, 1, '{cst_pkg::K_NEWLINE, 16'd1, 16'd0, 24'd0, 24'd1, 1'b0});
    add_row("{", 0, 1, '{cst_pkg::K_LBRACE, 16'd2, 16'd0, 24'd1, 24'd1, 1'b0});
    add_text("}()[];");
    add_text(" \t//x\n/*a*/\r\n#a\\\nb\n\"\\\"\"'c'0x1fUL a_1<<=->");
    add_row(8'h00, 0);
    add_row(8'hff, 1);
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    foreach (directed[i]) begin
      if (directed[i].typed) begin
        send_byte(directed[i].value, directed[i].last);
        if (expected_tokens.size() == 0 || expected_tokens[$] !== directed[i].tok) begin
          errors++;
          if (errors <= 10) $display("directed row %0d: predicted token differs", i);
        end
      end else begin
        send_byte(directed[i].value, directed[i].last);
      end
    end
    random_texts(40);
    write_tab(32'd1);
    hold_request = 1'b1;
    random_texts(40);
    wait_drained();
    random_texts(15);
    write_tab(32'd16);
    random_texts(40);
    write_tab(32'd0);
    random_texts(30);
    write_tab(32'd31);
    random_texts(30);
    write_tab(32'($urandom_range(16, 2)));
    idling_on = 1'b0;
    random_texts(30);
    wait_drained();
    done = 1'b1;
    $display("Sent %0d source bytes over six tab widths, checked %0d tokens.",
             bytes_sent, tokens_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end
endmodule
